### hdl/s256h_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Item types, state codes, round constants and the SHA-256 bit functions.
// ----------------------------------------------------------------------------
`default_nettype none

package s256h_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } core_state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_phase_t;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL      = 6'd56;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] r;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] r;
        unique case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

### hdl/s256h_front.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts input items and holds them in a short queue for the core.
// ----------------------------------------------------------------------------
`default_nettype none

module s256h_front #(
    parameter int DEPTH = 4
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   item_valid,
    output logic                  item_stall,
    input  s256h_pkg::in_item_t   item,
    output logic                  q_valid,
    input  wire                   q_take,
    output s256h_pkg::in_item_t   q_item
);
    import s256h_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    in_item_t          mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;
    logic              push, pop;

    assign item_stall = (count_reg == (AW+1)'(DEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != '0);
    assign pop        = q_valid && q_take;
    assign q_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

### hdl/s256h_core.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher core
// Packs bytes into the schedule window, pads, compresses and emits the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module s256h_core (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_valid,
    output logic                  q_take,
    input  s256h_pkg::in_item_t   q_item,
    output logic                  result_valid,
    input  wire                   result_stall,
    output s256h_pkg::out_item_t  result
);
    import s256h_pkg::*;

    core_state_t  st_reg, st_next;
    pad_phase_t   phase_reg, phase_next;
    logic [2:0]   len_idx_reg, len_idx_next;
    logic         finish_reg, finish_next;
    logic         pad_reg, pad_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  len_reg, len_next;
    logic [23:0]  acc_reg, acc_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   oidx_reg, oidx_next;
    logic         ov_reg, ov_next;
    out_item_t    od_reg, od_next;
    logic [31:0]  win_reg [16];
    logic [31:0]  win_next [16];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [31:0]  chain_reg [8];
    logic [31:0]  chain_next [8];

    logic         push_en;
    logic [7:0]   push_byte;
    logic         win_shift;
    logic [31:0]  win_in;
    logic [31:0]  w16, t1, t2;
    logic [63:0]  bit_len;

    assign bit_len = {len_reg, 3'b000};
    assign w16 = small_sigma1(win_reg[14]) + win_reg[9] + small_sigma0(win_reg[1]) + win_reg[0];
    assign t1  = v_reg[7] + big_sigma1(v_reg[4])
               + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
               + round_k(rnd_reg) + win_reg[0];
    assign t2  = big_sigma0(v_reg[0])
               + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign result_valid = ov_reg;
    assign result       = od_reg;

    always_comb
    begin
        st_next      = st_reg;
        phase_next   = phase_reg;
        len_idx_next = len_idx_reg;
        finish_next  = finish_reg;
        pad_next     = pad_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        rnd_next     = rnd_reg;
        oidx_next    = oidx_reg;
        ov_next      = ov_reg && result_stall;
        od_next      = od_reg;
        v_next       = v_reg;
        chain_next   = chain_reg;
        q_take       = 1'b0;
        push_en      = 1'b0;
        push_byte    = 8'h00;
        win_shift    = 1'b0;
        win_in       = {acc_reg, 8'h00};

        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    if (q_item.byte_present)
                    begin
                        push_en   = 1'b1;
                        push_byte = q_item.data_byte;
                        len_next  = len_reg + 61'd1;
                    end
                    if (q_item.end_message)
                    begin
                        pad_next     = 1'b1;
                        phase_next   = PAD_MARK;
                        len_idx_next = '0;
                        finish_next  = 1'b0;
                        st_next      = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (phase_reg == PAD_MARK)
                begin
                    push_byte  = PAD_MARK_BYTE;
                    phase_next = PAD_ZERO;
                end
                else if (phase_reg == PAD_LEN || fill_reg == LEN_FILL)
                begin
                    // Length bytes go out most significant first.
                    push_byte    = bit_len[8*(7 - len_idx_reg) +: 8];
                    phase_next   = PAD_LEN;
                    len_idx_next = len_idx_reg + 3'd1;
                    if (len_idx_reg == 3'd7)
                    begin
                        finish_next = 1'b1;
                    end
                end
                else
                begin
                    push_byte = 8'h00;
                end
            end
            ST_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                win_shift = 1'b1;
                win_in    = w16;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    st_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                if (finish_reg)
                begin
                    oidx_next = '0;
                    st_next   = ST_OUT;
                end
                else if (pad_reg)
                begin
                    st_next = ST_PAD;
                end
                else
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || !result_stall)
                begin
                    ov_next             = 1'b1;
                    od_next.digest_word = chain_reg[oidx_reg];
                    od_next.word_index  = oidx_reg;
                    od_next.last_word   = (oidx_reg == 3'd7);
                    oidx_next           = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_next[i] = init_hash(3'(i));
                        end
                        len_next    = '0;
                        pad_next    = 1'b0;
                        finish_next = 1'b0;
                        st_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        // A byte joins the word being built; every fourth byte enters the window,
        // and the sixty-fourth starts the rounds.
        if (push_en)
        begin
            acc_next  = {acc_reg[15:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg[1:0] == 2'b11)
            begin
                win_shift = 1'b1;
                win_in    = {acc_reg, push_byte};
            end
            if (fill_reg == 6'd63)
            begin
                v_next   = chain_reg;
                rnd_next = '0;
                st_next  = ST_ROUND;
            end
        end

        win_next = win_reg;
        if (win_shift)
        begin
            for (int j = 0; j < 15; j++)
            begin
                win_next[j] = win_reg[j + 1];
            end
            win_next[15] = win_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            phase_reg   <= PAD_MARK;
            len_idx_reg <= '0;
            finish_reg  <= 1'b0;
            pad_reg     <= 1'b0;
            fill_reg    <= '0;
            len_reg     <= '0;
            rnd_reg     <= '0;
            oidx_reg    <= '0;
            ov_reg      <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            st_reg      <= st_next;
            phase_reg   <= phase_next;
            len_idx_reg <= len_idx_next;
            finish_reg  <= finish_next;
            pad_reg     <= pad_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            rnd_reg     <= rnd_next;
            oidx_reg    <= oidx_next;
            ov_reg      <= ov_next;
            chain_reg   <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        od_reg  <= od_next;
        win_reg <= win_next;
        v_reg   <= v_next;
    end

endmodule

`default_nettype wire

### hdl/sha256_stream_hasher_unit.sv
// A byte item passes through the input queue and is then taken by the core.
// A completed 64-byte block runs 64 rounds on the single round unit
// and then folds the result into the chaining value.
// End of message: padding bytes fill one or two blocks, then 8 digest words go out.
// Reset loads the initial hash value and clears the length, fill and queue.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte stream in through a short queue, eight-word digest out per message.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   item_valid,
    output logic                  item_stall,
    input  s256h_pkg::in_item_t   item,
    output logic                  result_valid,
    input  wire                   result_stall,
    output s256h_pkg::out_item_t  result
);
    import s256h_pkg::*;

    logic     q_valid;
    logic     q_take;
    in_item_t q_item;

    s256h_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_take     (q_take),
        .q_item     (q_item)
    );

    s256h_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .q_item       (q_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Byte messages go in with random gaps, and every digest word is checked
// against a behavioural SHA-256 held in the bench. Results are stalled at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import s256h_pkg::*;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    in_item_t item;
    logic result_valid;
    logic result_stall;
    out_item_t result;

    sha256_stream_hasher_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Hasher state kept by the bench.
    logic [31:0] hash_h [8];
    logic [60:0] byte_count;
    logic [5:0]  fill;
    logic [7:0]  blk [64];

    in_item_t  pending_items [$];
    out_item_t digest_words [$];
    int        mismatches;
    int        words_seen;
    int        messages_done;
    logic      drive_on;
    logic      idle_free;
    logic      in_taken;

    function automatic logic [31:0] ror32(logic [31:0] x, int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, e, a;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = hash_h[i];
        for (int i = 0; i < 64; i++)
        begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + K_TAB[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_h[i] = hash_h[i] + v[i];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        blk[fill] = b;
        fill = fill + 6'd1;
        if (fill == 6'd0)
            compress_block();
    endtask

    task automatic hash_state_reset();
        for (int i = 0; i < 8; i++)
            hash_h[i] = H_INIT[i];
        byte_count = '0;
        fill = '0;
    endtask

    // Works out the digest words that an accepted word brings about.
    task automatic predict_digest(in_item_t it);
        logic [63:0] bit_len;
        out_item_t r;
        if (it.byte_present)
        begin
            byte_count = byte_count + 61'd1;
            absorb_byte(it.data_byte);
        end
        if (it.end_message)
        begin
            bit_len = {byte_count, 3'b000};
            absorb_byte(8'h80);
            while (fill != 6'd56)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(bit_len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                r.digest_word = hash_h[i];
                r.word_index = 3'(i);
                r.last_word = (i == 7);
                digest_words.push_back(r);
            end
            hash_state_reset();
        end
    endtask

    function automatic in_item_t make_word(logic [7:0] b, logic p, logic e);
        in_item_t it;
        it.data_byte = b;
        it.byte_present = p;
        it.end_message = e;
        return it;
    endfunction

    task automatic add_message(int len, int pattern);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (pattern)
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom);
            endcase
            // Now and then an ignored word with junk data sits in the stream.
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back(make_word(8'($urandom), 1'b0, 1'b0));
            if (i == len - 1 && $urandom_range(0, 1))
                pending_items.push_back(make_word(b, 1'b1, 1'b1));
            else
            begin
                pending_items.push_back(make_word(b, 1'b1, 1'b0));
                if (i == len - 1)
                    pending_items.push_back(make_word(8'($urandom), 1'b0, 1'b1));
            end
        end
        if (len == 0)
            pending_items.push_back(make_word(8'($urandom), 1'b0, 1'b1));
    endtask

    // The input handshake is sampled at the rising edge, where it takes effect.
    always @(posedge clk)
    begin
        in_taken <= rst_n && item_valid && !item_stall;
    end

    // Driver: presents words on the falling edge and holds them while stalled.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                predict_digest(item);
                void'(pending_items.pop_front());
            end
            if (!item_valid || in_taken)
            begin
                if (drive_on && pending_items.size() > 0 &&
                    (idle_free || $urandom_range(0, 99) >= 35))
                begin
                    item <= pending_items[0];
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
            result_stall <= !idle_free && ($urandom_range(0, 99) < 35);
        end
    end

    // Monitor: checks each accepted digest word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            words_seen <= words_seen + 1;
            if (result.last_word)
                messages_done <= messages_done + 1;
            if (digest_words.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected digest word %h index %0d", result.digest_word,
                             result.word_index);
            end
            else
            begin
                if (result !== digest_words[0])
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                                 digest_words[0].digest_word, digest_words[0].word_index,
                                 digest_words[0].last_word, result.digest_word,
                                 result.word_index, result.last_word);
                end
                void'(digest_words.pop_front());
            end
        end
    end

    initial
    begin
        #20ms;
        $display("[sha256_stream_hasher_unit] ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        drive_on = 1'b0;
        idle_free = 1'b0;
        mismatches = 0;
        words_seen = 0;
        messages_done = 0;
        hash_state_reset();
        for (int i = 0; i < 64; i++)
            blk[i] = '0;

        // Directed: empty message, "abc", ignored bytes, all-ones, block edges.
        pending_items.push_back(make_word(8'hff, 1'b0, 1'b1));
        pending_items.push_back(make_word(8'h61, 1'b1, 1'b0));
        pending_items.push_back(make_word(8'h5a, 1'b0, 1'b0));
        pending_items.push_back(make_word(8'h62, 1'b1, 1'b0));
        pending_items.push_back(make_word(8'h63, 1'b1, 1'b1));
        pending_items.push_back(make_word(8'h00, 1'b1, 1'b1));
        pending_items.push_back(make_word(8'hff, 1'b1, 1'b0));
        pending_items.push_back(make_word(8'hff, 1'b1, 1'b1));
        for (int i = 0; i < 5; i++)
            pending_items.push_back(make_word(8'h00, 1'b0, 1'b0));
        pending_items.push_back(make_word(8'h00, 1'b0, 1'b1));
        add_message(55, 0);
        add_message(56, 1);
        add_message(64, 2);
        add_message(120, 2);

        // Random messages, mostly short, a few spanning several blocks.
        while (pending_items.size() < 480)
        begin
            if ($urandom_range(0, 9) == 0)
                add_message($urandom_range(57, 130), 2);
            else
                add_message($urandom_range(0, 20), 2);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        drive_on = 1'b1;

        while (pending_items.size() > 0)
        begin
            @(posedge clk);
            // A stretch of the run with no idling on either side.
            idle_free = (pending_items.size() > 300 && pending_items.size() < 420);
        end
        while (digest_words.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Checked %0d digest words over %0d messages, %0d mismatches.",
                 words_seen, messages_done, mismatches);
        if (mismatches == 0 && digest_words.size() == 0)
            $display("[sha256_stream_hasher_unit] OK");
        else
            $display("[sha256_stream_hasher_unit] ERROR");
        $finish;
    end
endmodule

`default_nettype wire

### sha256_stream_hasher_unit.f
hdl/s256h_pkg.sv
hdl/s256h_front.sv
hdl/s256h_core.sv
hdl/sha256_stream_hasher_unit.sv
test/tb_top.sv
